### rtl/rts_pkg.sv
// shared types and constants for the range translation splitter
`default_nettype none

package rts_pkg;

   // fixed field widths
   localparam int IDX_FIELD_W = 4;
   localparam int CFG_N_W     = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index (word address bit)
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   // request kinds
   localparam logic KIND_LOAD      = 1'b0;
   localparam logic KIND_TRANSLATE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic scan;
      logic fetch;
      logic skip;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic walk_done;
      logic skip_entry;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/rts_ctrl.sv
// controller state machine for the range translation splitter
`default_nettype none

module rts_ctrl
   import rts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_kind,
   input  wire status_type status,
   output logic            req_tready,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_kind == KIND_TRANSLATE)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.scan_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.skip_entry || status.out_free) begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            cmd.scan = !status.scan_done;
         end
         ST_FETCH: begin
            cmd.fetch = !status.walk_done;
         end
         ST_EMIT: begin
            if (status.skip_entry) begin
               cmd.skip = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/rts_datapath.sv
// table, walk registers and result register of the range translation splitter
`default_nettype none

module rts_datapath
   import rts_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int VALUE_WIDTH   = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [CFG_N_W-1:0]     entries_in_use,
   input  wire logic [IDX_FIELD_W-1:0] entry_index,
   input  wire logic [VALUE_WIDTH-1:0] entry_source,
   input  wire logic [VALUE_WIDTH-1:0] entry_dest,
   input  wire logic [VALUE_WIDTH-1:0] entry_length,
   input  wire logic [VALUE_WIDTH-1:0] range_start,
   input  wire logic [VALUE_WIDTH-1:0] range_size,
   output logic [VALUE_WIDTH-1:0]      chunk_start,
   output logic [VALUE_WIDTH-1:0]      chunk_size,
   output logic                        was_translated,
   output logic                        last_chunk,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int KW = CW + 1;

   // translation table
   logic [VALUE_WIDTH-1:0] src_table_ff [TABLE_ENTRIES];
   logic [VALUE_WIDTH-1:0] dst_table_ff [TABLE_ENTRIES];
   logic [VALUE_WIDTH-1:0] len_table_ff [TABLE_ENTRIES];

   // walk state
   logic [VALUE_WIDTH-1:0] pos_ff;
   logic [VALUE_WIDTH-1:0] rem_ff;
   logic [CW-1:0]          n_ff;
   logic [CW-1:0]          idx_ff;
   logic [CW-1:0]          scan_ff;
   logic [KW-1:0]          count_ff;
   logic                   past_top_ff;

   // fetched entry stage
   logic                   in_entry_ff;
   logic                   below_ff;
   logic [VALUE_WIDTH-1:0] gap_ff;
   logic [VALUE_WIDTH-1:0] off_ff;
   logic [VALUE_WIDTH-1:0] e_len_ff;
   logic [VALUE_WIDTH-1:0] e_dst_ff;

   // result register
   logic [VALUE_WIDTH-1:0] chunk_start_ff;
   logic [VALUE_WIDTH-1:0] chunk_size_ff;
   logic                   moved_ff;
   logic                   last_ff;
   logic                   rsp_tvalid_ff;

   logic [IW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_src;
   logic [VALUE_WIDTH-1:0] rd_dst;
   logic [VALUE_WIDTH-1:0] rd_len;
   logic [KW-1:0]          cap;
   logic [VALUE_WIDTH-1:0] lead;
   logic                   over;
   logic                   moved;
   logic [VALUE_WIDTH-1:0] cand;
   logic [VALUE_WIDTH-1:0] act0;
   logic [VALUE_WIDTH-1:0] room;
   logic [VALUE_WIDTH-1:0] act;
   logic [VALUE_WIDTH-1:0] first;
   logic [VALUE_WIDTH-1:0] rem_in;
   logic                   hit_top;
   logic                   last;

   // table writes from load requests
   always_ff @(posedge clock) begin
      if (cmd.load && (int'(entry_index) < TABLE_ENTRIES)) begin
         src_table_ff[IW'(entry_index)] <= entry_source;
         dst_table_ff[IW'(entry_index)] <= entry_dest;
         len_table_ff[IW'(entry_index)] <= entry_length;
      end
   end

   // single read port: scan pointer while searching, walk pointer otherwise
   assign rd_addr = cmd.scan ? scan_ff[IW-1:0] : idx_ff[IW-1:0];
   assign rd_src  = src_table_ff[rd_addr];
   assign rd_dst  = dst_table_ff[rd_addr];
   assign rd_len  = len_table_ff[rd_addr];

   assign cap = {n_ff, 1'b1};

   // step evaluation on the fetched entry
   always_comb begin
      lead  = e_len_ff - off_ff;
      over  = (off_ff >= e_len_ff);
      moved = in_entry_ff && !below_ff;
      if (!in_entry_ff) begin
         cand = rem_ff;
      end else if (below_ff) begin
         cand = gap_ff;
      end else begin
         cand = lead;
      end
      act0 = (cand < rem_ff) ? cand : rem_ff;
      room = ~pos_ff;
      // nothing may cross the top of the value space
      if (!past_top_ff && ((act0 - VALUE_WIDTH'(1)) > room)) begin
         act = room + VALUE_WIDTH'(1);
      end else begin
         act = act0;
      end
      hit_top = !past_top_ff && ((act - VALUE_WIDTH'(1)) == room);
      first   = moved ? (off_ff + e_dst_ff) : pos_ff;
      rem_in  = rem_ff - act;
      last    = (rem_in == '0) || ((count_ff + KW'(1)) == cap);
   end

   // status
   assign status.scan_done  = (scan_ff == n_ff);
   assign status.walk_done  = (rem_ff == '0) || (count_ff == cap);
   assign status.skip_entry = in_entry_ff && !below_ff && over;
   assign status.out_free   = !rsp_tvalid_ff || rsp_tready;

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff      <= range_start;
         rem_ff      <= range_size;
         n_ff        <= (int'(entries_in_use) > TABLE_ENTRIES) ?
                        CW'(TABLE_ENTRIES) : CW'(entries_in_use);
         idx_ff      <= '0;
         scan_ff     <= '0;
         count_ff    <= '0;
         past_top_ff <= 1'b0;
      end
      // search for the last entry at or below the range start
      if (cmd.scan) begin
         if (rd_src <= pos_ff) begin
            idx_ff <= scan_ff;
         end
         scan_ff <= scan_ff + CW'(1);
      end
      if (cmd.skip) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.emit) begin
         count_ff    <= count_ff + KW'(1);
         rem_ff      <= rem_in;
         pos_ff      <= pos_ff + act;
         past_top_ff <= past_top_ff || hit_top;
      end
   end

   // entry fetch stage
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         in_entry_ff <= !past_top_ff && (idx_ff < n_ff);
         below_ff    <= (pos_ff < rd_src);
         gap_ff      <= rd_src - pos_ff;
         off_ff      <= pos_ff - rd_src;
         e_len_ff    <= rd_len;
         e_dst_ff    <= rd_dst;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         chunk_start_ff <= first;
         chunk_size_ff  <= act;
         moved_ff       <= moved;
         last_ff        <= last;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign chunk_start    = chunk_start_ff;
   assign chunk_size     = chunk_size_ff;
   assign was_translated = moved_ff;
   assign last_chunk     = last_ff;
   assign rsp_tvalid     = rsp_tvalid_ff;

endmodule

`default_nettype wire

### rtl/range_translation_splitter_core.sv
// top level of the range translation splitter: ports, csr and unpacking
`default_nettype none

// Range translation splitter. A load request (tuser 0) writes one table entry
// (source base, destination base, length) and returns nothing. A
// translate request (tuser 1) splits its range into chunks: pieces inside an
// entry come out moved by dest - source with tuser 1, pieces outside every
// entry pass through with tuser 0, and tlast marks the final chunk; a zero-size
// range gives nothing. Load entries in ascending order of source base and set
// entries_in_use (csr address 0) only while idle. A translate request scans
// the entries in use to find its starting entry, one table read a cycle,
// then fetches an entry and takes a step for every entry stepped over and
// every chunk sent, and a final fetch closes the walk. A chunk step waits
// while the result register holds a chunk that rsp_tready has not taken.
// Requests are taken one at a time.
module range_translation_splitter_core
   import rts_pkg::*;
#(
   parameter int  TABLE_ENTRIES = 16,
   parameter int  VALUE_WIDTH   = 32,
   localparam int REQ_DW = ((IDX_FIELD_W + 5 * VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_DW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // entry_index, entry_source, entry_dest, entry_length, range_start, range_size
   input  wire logic [REQ_DW-1:0]     req_tdata,
   // kind
   input  wire logic                  req_tuser,
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // chunk_start, chunk_size
   output logic [RSP_DW-1:0]          rsp_tdata,
   // was_translated
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [CFG_N_W-1:0]     entries_in_use_ff;
   logic                   csr_write;

   logic [IDX_FIELD_W-1:0] entry_index;
   logic [VALUE_WIDTH-1:0] entry_source;
   logic [VALUE_WIDTH-1:0] entry_dest;
   logic [VALUE_WIDTH-1:0] entry_length;
   logic [VALUE_WIDTH-1:0] range_start;
   logic [VALUE_WIDTH-1:0] range_size;
   logic [VALUE_WIDTH-1:0] chunk_start;
   logic [VALUE_WIDTH-1:0] chunk_size;

   cmd_type                cmd;
   status_type             status;

   // csr register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == REG_ENTRIES_IN_USE)) begin
         entries_in_use_ff <= csr_pwdata[CFG_N_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ENTRIES_IN_USE) ?
                       CSR_DATA_W'(entries_in_use_ff) : '0;

   // request unpacking
   assign entry_index  = req_tdata[IDX_FIELD_W-1:0];
   assign entry_source = req_tdata[IDX_FIELD_W                   +: VALUE_WIDTH];
   assign entry_dest   = req_tdata[IDX_FIELD_W + VALUE_WIDTH     +: VALUE_WIDTH];
   assign entry_length = req_tdata[IDX_FIELD_W + 2 * VALUE_WIDTH +: VALUE_WIDTH];
   assign range_start  = req_tdata[IDX_FIELD_W + 3 * VALUE_WIDTH +: VALUE_WIDTH];
   assign range_size   = req_tdata[IDX_FIELD_W + 4 * VALUE_WIDTH +: VALUE_WIDTH];

   // result packing
   assign rsp_tdata = RSP_DW'({chunk_size, chunk_start});

   rts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   rts_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .entries_in_use (entries_in_use_ff),
      .entry_index    (entry_index),
      .entry_source   (entry_source),
      .entry_dest     (entry_dest),
      .entry_length   (entry_length),
      .range_start    (range_start),
      .range_size     (range_size),
      .chunk_start    (chunk_start),
      .chunk_size     (chunk_size),
      .was_translated (rsp_tuser),
      .last_chunk     (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready)
   );

endmodule

`default_nettype wire
